[rtl/rtnv_pkg.sv]
`default_nettype none
package rtnv_pkg;

  localparam int PIX_W    = 8;
  localparam int ACC_W    = 26;
  localparam int FRAC_W   = 16;
  localparam int CFG_W    = 13;
  localparam int ADDR_W   = 24;
  localparam int COFF_W   = 23;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 72;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [PIX_W-1:0] pix_t;

  localparam acc_t KY_R = ACC_W'(16843);
  localparam acc_t KY_G = ACC_W'(33030);
  localparam acc_t KY_B = ACC_W'(6423);
  localparam acc_t KU_R = ACC_W'(9699);
  localparam acc_t KU_G = ACC_W'(19071);
  localparam acc_t KU_B = ACC_W'(28770);
  localparam acc_t KV_R = ACC_W'(28770);
  localparam acc_t KV_G = ACC_W'(24117);
  localparam acc_t KV_B = ACC_W'(4653);
  localparam acc_t OFS_Y = ACC_W'(16 << FRAC_W);
  localparam acc_t OFS_C = ACC_W'(128 << FRAC_W);
  localparam pix_t PIX_MAX = 8'd255;

  localparam logic [COFF_W-1:0] COFF_STEP = COFF_W'(2);

  // tdata layout of a result item
  localparam int LUMA_LSB = 0;
  localparam int ADDR_LSB = 8;
  localparam int CB_LSB   = 32;
  localparam int CR_LSB   = 40;
  localparam int COFF_LSB = 48;
  localparam int PAD_LSB  = 71;

endpackage
`default_nettype wire

[rtl/rtnv_csc.sv]
`default_nettype none
module rtnv_csc (
  input  wire rtnv_pkg::pix_t red,
  input  wire rtnv_pkg::pix_t green,
  input  wire rtnv_pkg::pix_t blue,
  output rtnv_pkg::pix_t      luma,
  output rtnv_pkg::pix_t      cb,
  output rtnv_pkg::pix_t      cr
);
  import rtnv_pkg::*;

  function automatic pix_t clamp_q16(input acc_t acc);
    acc_t sh;
    sh = acc >>> FRAC_W;
    if (acc < 0) begin
      return '0;
    end else if (sh > acc_t'(PIX_MAX)) begin
      return PIX_MAX;
    end else begin
      return PIX_W'(sh);
    end
  endfunction

  acc_t r_s;
  acc_t g_s;
  acc_t b_s;
  acc_t acc_y;
  acc_t acc_u;
  acc_t acc_v;

  assign r_s = acc_t'(red);
  assign g_s = acc_t'(green);
  assign b_s = acc_t'(blue);

  assign acc_y = KY_R * r_s + KY_G * g_s + KY_B * b_s + OFS_Y;
  assign acc_u = KU_B * b_s - KU_R * r_s - KU_G * g_s + OFS_C;
  assign acc_v = KV_R * r_s - KV_G * g_s - KV_B * b_s + OFS_C;

  assign luma = clamp_q16(acc_y);
  assign cb   = clamp_q16(acc_u);
  assign cr   = clamp_q16(acc_v);

endmodule
`default_nettype wire

[rtl/rgb_to_nv12_converter.sv]
// RGB to NV12 converter (BT.601 studio range, 4:2:0 by top-left pick).
// Input channel s_*: one RGB pixel per item in raster order.
// Output channel m_*: one result item per pixel with the luma byte and its
//   plane address; m_tuser marks pixels at an even column of an even row,
//   which also carry U, V and the U byte offset in the interleaved chroma
//   plane (zero otherwise). m_tlast marks the last pixel of the frame.
// Config port: cfg_index 0 sets the line width, 1 the line count. A value of
//   0 acts as 1, a value above MAX_WIDTH / MAX_HEIGHT acts as that maximum.
//   Write only while no item is in flight.
// Throughput: one item per clock while m_tready is high. Pipeline: an input
//   stage holding the pixel and its position, then the result register after
//   the color matrix and the row by width address multiply.
// Reset: counters return to the first pixel of a frame, sizes to 1280 x 720,
//   both stages empty.
// Stall: while m_tready is low the result holds; s_tready stays high until
//   the input stage is also full.
`default_nettype none
module rgb_to_nv12_converter #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  // red[7:0], green[15:8], blue[23:16]
  input  wire  [rtnv_pkg::S_DATA_W-1:0]      s_tdata,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // luma[7:0], luma_address[31:8], chroma_u[39:32], chroma_v[47:40],
  // chroma_offset[70:48], zero[71]
  output logic [rtnv_pkg::M_DATA_W-1:0]      m_tdata,
  // chroma_valid[0]
  output logic                               m_tuser,
  output logic                               m_tlast,
  input  wire                                cfg_write,
  input  wire                                cfg_index,
  input  wire  [rtnv_pkg::CFG_W-1:0]         cfg_data
);
  import rtnv_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int WCMP  = WW + 1;
  localparam int HCMP  = HW + 1;
  localparam int PW    = RW + WW;
  localparam int W_RST = (1280 > MAX_WIDTH) ? MAX_WIDTH : 1280;
  localparam int H_RST = (720 > MAX_HEIGHT) ? MAX_HEIGHT : 720;

  logic [WW-1:0]     width_eff;
  logic [HW-1:0]     height_eff;
  logic [WW-1:0]     width_cfg;
  logic [HW-1:0]     height_cfg;

  logic [CW-1:0]     column_count;
  logic [RW-1:0]     row_count;
  logic [COFF_W-1:0] chroma_pair_offset;

  logic              in_accept;
  logic              out_ready;
  logic              cvalid;
  logic              line_end;
  logic              frame_end;

  logic              s1_valid;
  pix_t              s1_red;
  pix_t              s1_green;
  pix_t              s1_blue;
  logic [CW-1:0]     s1_col;
  logic [RW-1:0]     s1_row;
  logic [WW-1:0]     s1_width;
  logic              s1_cvalid;
  logic              s1_last;
  logic [COFF_W-1:0] s1_coff;

  pix_t              luma;
  pix_t              cb;
  pix_t              cr;
  logic [PW-1:0]     addr_prod;
  logic [ADDR_W-1:0] luma_address;

  assign width_cfg  = (cfg_data == '0) ? WW'(1) :
                      (32'(cfg_data) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_data);
  assign height_cfg = (cfg_data == '0) ? HW'(1) :
                      (32'(cfg_data) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WW'(W_RST);
      height_eff <= HW'(H_RST);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IDX_WIDTH:  width_eff  <= width_cfg;
        CFG_IDX_HEIGHT: height_eff <= height_cfg;
        default: ;
      endcase
    end
  end

  assign out_ready = !m_tvalid || m_tready;
  assign s_tready  = !s1_valid || out_ready;
  assign in_accept = s_tvalid && s_tready;

  assign cvalid    = !column_count[0] && !row_count[0];
  assign line_end  = (WCMP'(column_count) + WCMP'(1)) >= WCMP'(width_eff);
  assign frame_end = line_end && ((HCMP'(row_count) + HCMP'(1)) >= HCMP'(height_eff));

  // advance position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count       <= '0;
      row_count          <= '0;
      chroma_pair_offset <= '0;
    end else if (in_accept) begin
      if (frame_end) begin
        column_count       <= '0;
        row_count          <= '0;
        chroma_pair_offset <= '0;
      end else begin
        if (cvalid) begin
          chroma_pair_offset <= chroma_pair_offset + COFF_STEP;
        end
        if (line_end) begin
          column_count <= '0;
          row_count    <= row_count + RW'(1);
        end else begin
          column_count <= column_count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_red    <= s_tdata[7:0];
      s1_green  <= s_tdata[15:8];
      s1_blue   <= s_tdata[23:16];
      s1_col    <= column_count;
      s1_row    <= row_count;
      s1_width  <= width_eff;
      s1_cvalid <= cvalid;
      s1_last   <= frame_end;
      s1_coff   <= chroma_pair_offset;
    end
  end

  rtnv_csc u_csc (
    .red   (s1_red),
    .green (s1_green),
    .blue  (s1_blue),
    .luma  (luma),
    .cb    (cb),
    .cr    (cr)
  );

  assign addr_prod    = PW'(s1_row) * PW'(s1_width);
  assign luma_address = ADDR_W'(addr_prod + PW'(s1_col));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid) begin
      m_tdata[CB_LSB-1:LUMA_LSB]   <= {luma_address, luma};
      m_tdata[CR_LSB-1:CB_LSB]     <= s1_cvalid ? cb : '0;
      m_tdata[COFF_LSB-1:CR_LSB]   <= s1_cvalid ? cr : '0;
      m_tdata[PAD_LSB-1:COFF_LSB]  <= s1_cvalid ? s1_coff : '0;
      m_tdata[M_DATA_W-1:PAD_LSB]  <= '0;
      m_tuser                      <= s1_cvalid;
      m_tlast                      <= s1_last;
    end
  end

endmodule
`default_nettype wire

[rtl/rtnv_checker.sv]
`default_nettype none
module rtnv_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              s_tvalid,
  input wire                              s_tready,
  input wire                              m_tvalid,
  input wire                              m_tready,
  input wire [rtnv_pkg::M_DATA_W-1:0]     m_tdata,
  input wire                              m_tuser,
  input wire                              m_tlast
);
  import rtnv_pkg::*;

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result item changed");

  a_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[M_DATA_W-1:CB_LSB] == '0)
    else $error("chroma fields set on a luma-only item");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  a_fill_needs_input: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid ##1 !m_tvalid ##1 m_tvalid |-> $past(s_tvalid && s_tready, 2))
    else $error("result item with no input item");

endmodule

bind rgb_to_nv12_converter rtnv_checker u_rtnv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire
